>>> sv/timebase_ns_tick_converter_defines.svh
`ifndef TIMEBASE_NS_TICK_CONVERTER_DEFINES_SVH
`define TIMEBASE_NS_TICK_CONVERTER_DEFINES_SVH

// Checks that a condition implies another in the same cycle.
`define TNTC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that a condition implies another in the next cycle.
`define TNTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/tntc_pkg.sv
package tntc_pkg;

   localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
   localparam logic [19:0] NS_PER_MS  = 20'd1000000;
   localparam logic [6:0]  MAX_SHIFT  = 7'd127;

   localparam logic [1:0] MODE_TO_NS     = 2'd0;
   localparam logic [1:0] MODE_TO_TICKS  = 2'd1;
   localparam logic [1:0] MODE_DEADLINE  = 2'd2;
   localparam logic [1:0] MODE_WAIT      = 2'd3;

endpackage

>>> sv/timebase_ns_tick_converter.sv
// One item per cycle is sustained while the response side is ready and no calibration is running.
// The pipeline has six stages; the 64 by 64 multiply is split into four 32 by 32 products.
// A nonzero frequency write starts a calibration, a limit step, a binary search for the shift
// and a bit-serial divide for each of the two factors, during which no input transfer is taken.
// Reset is synchronous and active high; it clears the frequency, both factors and all
// valid bits, leaving the block uncalibrated.
`include "timebase_ns_tick_converter_defines.svh"

module timebase_ns_tick_converter (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // amount [63:0], current_count [127:64], start_count [191:128]
   input  logic [191:0] req_tdata,
   // mode [1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_value [63:0], wait_done [64], uncalibrated [65], zero [71:66]
   output logic [71:0]  rsp_tdata
);

   typedef enum logic [1:0] {
      CAL_IDLE,
      CAL_LIMIT,
      CAL_SEARCH,
      CAL_DIVIDE
   } cal_state_type;

   cal_state_type cal_state_ff;
   logic [31:0]  hz_ff;
   logic         factor_ff;
   logic [127:0] lim_ff;
   logic [6:0]   lo_ff;
   logic [6:0]   hi_ff;
   logic [127:0] n_ff;
   logic [63:0]  rem_ff;
   logic [63:0]  q_ff;
   logic [6:0]   cnt_ff;
   logic [63:0]  ns_mult_ff;
   logic [6:0]   ns_shift_ff;
   logic [63:0]  tick_mult_ff;
   logic [6:0]   tick_shift_ff;

   logic [63:0]  num;
   logic [63:0]  den;
   logic [7:0]   mid_sum;
   logic [6:0]   mid;
   logic         fits;
   logic         div_bit;
   logic [63:0]  rem_sh;
   logic         sub;
   logic [63:0]  rem_in;
   logic [63:0]  q_in;

   assign num     = factor_ff ? {32'b0, hz_ff} : tntc_pkg::NS_PER_SEC;
   assign den     = factor_ff ? tntc_pkg::NS_PER_SEC : {32'b0, hz_ff};
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} + 8'd1;
   assign mid     = mid_sum[7:1];
   assign fits    = (({64'b0, num} << mid) <= lim_ff);
   assign div_bit = n_ff[127];
   assign rem_sh  = {rem_ff[62:0], div_bit};
   assign sub     = rem_ff[63] || (rem_sh >= den);
   assign rem_in  = sub ? rem_sh - den : rem_sh;
   assign q_in    = {q_ff[62:0], sub};

   assign csr_ready = (cal_state_ff == CAL_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_state_ff  <= CAL_IDLE;
         hz_ff         <= 32'd0;
         factor_ff     <= 1'b0;
         ns_mult_ff    <= 64'd0;
         ns_shift_ff   <= 7'd0;
         tick_mult_ff  <= 64'd0;
         tick_shift_ff <= 7'd0;
      end else begin
         unique case (cal_state_ff)
            CAL_IDLE: begin
               if (csr_valid) begin
                  hz_ff     <= csr_data;
                  factor_ff <= 1'b0;
                  if (csr_data == 32'd0) begin
                     ns_mult_ff    <= 64'd0;
                     ns_shift_ff   <= 7'd0;
                     tick_mult_ff  <= 64'd0;
                     tick_shift_ff <= 7'd0;
                  end else begin
                     cal_state_ff <= CAL_LIMIT;
                  end
               end
            end
            CAL_LIMIT: begin
               lim_ff       <= {den, 64'b0} - {64'b0, den};
               lo_ff        <= 7'd0;
               hi_ff        <= tntc_pkg::MAX_SHIFT;
               cal_state_ff <= CAL_SEARCH;
            end
            CAL_SEARCH: begin
               if (lo_ff < hi_ff) begin
                  if (fits) begin
                     lo_ff <= mid;
                  end else begin
                     hi_ff <= mid - 7'd1;
                  end
               end else begin
                  n_ff   <= {64'b0, num} << lo_ff;
                  rem_ff <= 64'd0;
                  q_ff   <= 64'd0;
                  cnt_ff <= 7'd0;
                  if (factor_ff) begin
                     tick_shift_ff <= lo_ff;
                  end else begin
                     ns_shift_ff <= lo_ff;
                  end
                  cal_state_ff <= CAL_DIVIDE;
               end
            end
            CAL_DIVIDE: begin
               n_ff   <= {n_ff[126:0], 1'b0};
               rem_ff <= rem_in;
               q_ff   <= q_in;
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == tntc_pkg::MAX_SHIFT) begin
                  if (factor_ff) begin
                     tick_mult_ff <= q_in;
                     cal_state_ff <= CAL_IDLE;
                  end else begin
                     ns_mult_ff   <= q_in;
                     factor_ff    <= 1'b1;
                     cal_state_ff <= CAL_LIMIT;
                  end
               end
            end
            default: cal_state_ff <= CAL_IDLE;
         endcase
      end
   end

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic en1, en2, en3, en4, en5, en6;

   assign en6 = !s6_valid_ff || rsp_tready;
   assign en5 = !s5_valid_ff || en6;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign req_tready = en1 && (cal_state_ff == CAL_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_tvalid && req_tready;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
         if (en5) s5_valid_ff <= s4_valid_ff;
         if (en6) s6_valid_ff <= s5_valid_ff;
      end
   end

   logic [1:0]   s1_mode_ff, s2_mode_ff, s3_mode_ff, s4_mode_ff, s5_mode_ff, s6_mode_ff;
   logic [63:0]  s1_amount_ff;
   logic [63:0]  s1_now_ff, s2_now_ff, s3_now_ff, s4_now_ff, s5_now_ff;
   logic [63:0]  s1_start_ff, s2_start_ff, s3_start_ff, s4_start_ff;
   logic [51:0]  s1_pa_lo_ff;
   logic [31:0]  s1_pa_hi_ff;
   logic [63:0]  s2_v_ff;
   logic [63:0]  s2_mult_ff;
   logic [6:0]   s2_shift_ff, s3_shift_ff, s4_shift_ff;
   logic [63:0]  s3_p0_ff, s3_p1_ff, s3_p2_ff, s3_p3_ff;
   logic [127:0] s4_prod_ff;
   logic [63:0]  s5_val_ff;
   logic [63:0]  s5_elapsed_ff;
   logic [63:0]  s6_result_ff;
   logic         s6_done_ff;
   logic         hz_zero;

   assign hz_zero = (hz_ff == 32'd0);

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_mode_ff   <= req_tuser;
         s1_amount_ff <= req_tdata[63:0];
         s1_now_ff    <= req_tdata[127:64];
         s1_start_ff  <= req_tdata[191:128];
         s1_pa_lo_ff  <= 52'(req_tdata[31:0]) * 52'(tntc_pkg::NS_PER_MS);
         s1_pa_hi_ff  <= 32'(52'(req_tdata[63:32]) * 52'(tntc_pkg::NS_PER_MS));
      end
      if (en2) begin
         s2_mode_ff  <= s1_mode_ff;
         s2_now_ff   <= s1_now_ff;
         s2_start_ff <= s1_start_ff;
         s2_v_ff     <= s1_mode_ff[1] ? ({12'b0, s1_pa_lo_ff} + {s1_pa_hi_ff, 32'b0})
                                      : s1_amount_ff;
         if (s1_mode_ff == tntc_pkg::MODE_TO_NS) begin
            s2_mult_ff  <= ns_mult_ff;
            s2_shift_ff <= ns_shift_ff;
         end else begin
            s2_mult_ff  <= tick_mult_ff;
            s2_shift_ff <= tick_shift_ff;
         end
      end
      if (en3) begin
         s3_mode_ff  <= s2_mode_ff;
         s3_now_ff   <= s2_now_ff;
         s3_start_ff <= s2_start_ff;
         s3_shift_ff <= s2_shift_ff;
         s3_p0_ff    <= 64'(s2_v_ff[31:0])  * 64'(s2_mult_ff[31:0]);
         s3_p1_ff    <= 64'(s2_v_ff[31:0])  * 64'(s2_mult_ff[63:32]);
         s3_p2_ff    <= 64'(s2_v_ff[63:32]) * 64'(s2_mult_ff[31:0]);
         s3_p3_ff    <= 64'(s2_v_ff[63:32]) * 64'(s2_mult_ff[63:32]);
      end
      if (en4) begin
         s4_mode_ff  <= s3_mode_ff;
         s4_now_ff   <= s3_now_ff;
         s4_start_ff <= s3_start_ff;
         s4_shift_ff <= s3_shift_ff;
         s4_prod_ff  <= {64'b0, s3_p0_ff} + {32'b0, s3_p1_ff, 32'b0}
                      + {32'b0, s3_p2_ff, 32'b0} + {s3_p3_ff, 64'b0};
      end
      if (en5) begin
         s5_mode_ff    <= s4_mode_ff;
         s5_now_ff     <= s4_now_ff;
         s5_val_ff     <= 64'(s4_prod_ff >> s4_shift_ff);
         s5_elapsed_ff <= s4_now_ff - s4_start_ff;
      end
      if (en6) begin
         s6_mode_ff   <= s5_mode_ff;
         s6_result_ff <= (s5_mode_ff == tntc_pkg::MODE_DEADLINE) ? s5_now_ff + s5_val_ff
                                                                 : s5_val_ff;
         s6_done_ff   <= (s5_mode_ff == tntc_pkg::MODE_WAIT)
                         && (hz_zero || (s5_elapsed_ff >= s5_val_ff));
      end
   end

   assign rsp_tvalid = s6_valid_ff;
   assign rsp_tdata  = {6'b0, hz_zero, s6_done_ff, s6_result_ff};

   `TNTC_ASSERT_SAME(a_uncal_zero, clock, reset,
      rsp_tvalid && hz_zero && (s6_mode_ff != tntc_pkg::MODE_DEADLINE),
      s6_result_ff == 64'd0)
   `TNTC_ASSERT_SAME(a_done_only_wait, clock, reset,
      rsp_tvalid && (s6_mode_ff != tntc_pkg::MODE_WAIT), !s6_done_ff)
   `TNTC_ASSERT_NEXT(a_cal_blocks_input, clock, reset,
      csr_valid && csr_ready && (csr_data != 32'd0), !req_tready)

endmodule

>>> tb/timebase_ns_tick_converter_tb.sv
module timebase_ns_tick_converter_tb;

   logic         clock;
   logic         reset;
   logic         csr_valid;
   logic         csr_ready;
   logic [31:0]  csr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;

   timebase_ns_tick_converter uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   localparam int IDLE_LIMIT = 3000;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic [31:0]  hz_model;
   logic [63:0]  ns_mult_model;
   logic [6:0]   ns_shift_model;
   logic [63:0]  tick_mult_model;
   logic [6:0]   tick_shift_model;
   logic [71:0]  pending_results[$];
   int           mismatches;
   int           items_sent;
   int           results_checked;
   int           freq_writes;
   int           idle_cycles;
   bit           no_gaps;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [6:0] find_shift(logic [63:0] num, logic [63:0] den);
      logic [127:0] lim;
      logic [127:0] shifted;
      int lo;
      int hi;
      int mid;
      lim = {64'd0, den} * {64'd0, ALL_ONES};
      lo = 0;
      hi = 127;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         shifted = {64'd0, num} << mid;
         if (shifted <= lim) lo = mid;
         else hi = mid - 1;
      end
      return lo[6:0];
   endfunction

   function automatic logic [63:0] find_mult(logic [63:0] num, logic [63:0] den,
                                             logic [6:0] sh);
      logic [127:0] shifted;
      logic [127:0] quot;
      shifted = {64'd0, num} << sh;
      quot = shifted / {64'd0, den};
      return quot[63:0];
   endfunction

   function automatic logic [63:0] rescale(logic [63:0] v, logic [63:0] mult,
                                           logic [6:0] sh);
      logic [127:0] prod;
      if (hz_model == 32'd0) return 64'd0;
      prod = {64'd0, v} * {64'd0, mult};
      prod = prod >> sh;
      return prod[63:0];
   endfunction

   function automatic logic [71:0] convert(logic [1:0] mode, logic [63:0] amount,
                                           logic [63:0] now, logic [63:0] start);
      logic [63:0] value;
      logic [63:0] ticks;
      logic        done;
      logic [63:0] amount_ns;
      done = 1'b0;
      amount_ns = amount * {44'd0, tntc_pkg::NS_PER_MS};
      ticks = rescale(amount_ns, tick_mult_model, tick_shift_model);
      case (mode)
         tntc_pkg::MODE_TO_NS: value = rescale(amount, ns_mult_model, ns_shift_model);
         tntc_pkg::MODE_TO_TICKS: value = rescale(amount, tick_mult_model, tick_shift_model);
         tntc_pkg::MODE_DEADLINE: value = now + ticks;
         default: begin
            value = ticks;
            done = (hz_model == 32'd0) || ((now - start) >= ticks);
         end
      endcase
      return {6'd0, hz_model == 32'd0, done, value};
   endfunction

   task automatic set_frequency(logic [31:0] hz);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= hz;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      hz_model = hz;
      if (hz == 32'd0) begin
         ns_mult_model = 64'd0;
         ns_shift_model = 7'd0;
         tick_mult_model = 64'd0;
         tick_shift_model = 7'd0;
      end else begin
         ns_shift_model = find_shift(tntc_pkg::NS_PER_SEC, {32'd0, hz});
         tick_shift_model = find_shift({32'd0, hz}, tntc_pkg::NS_PER_SEC);
         ns_mult_model = find_mult(tntc_pkg::NS_PER_SEC, {32'd0, hz}, ns_shift_model);
         tick_mult_model = find_mult({32'd0, hz}, tntc_pkg::NS_PER_SEC, tick_shift_model);
      end
      freq_writes++;
   endtask

   task automatic send_item(logic [1:0] mode, logic [63:0] amount, logic [63:0] now,
                            logic [63:0] start);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {start, now, amount};
      pending_results.push_back(convert(mode, amount, now, start));
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_all_modes(logic [63:0] amount, logic [63:0] now,
                                 logic [63:0] start);
      send_item(tntc_pkg::MODE_TO_NS, amount, now, start);
      send_item(tntc_pkg::MODE_TO_TICKS, amount, now, start);
      send_item(tntc_pkg::MODE_DEADLINE, amount, now, start);
      send_item(tntc_pkg::MODE_WAIT, amount, now, start);
   endtask

   task automatic test_uncalibrated();
      send_all_modes(64'd0, 64'd0, 64'd0);
      send_all_modes(ALL_ONES, ALL_ONES, 64'd0);
      send_item(tntc_pkg::MODE_WAIT, 64'd5, 64'd3, 64'd7);
      end_burst();
   endtask

   task automatic test_directed();
      set_frequency(32'd10_000_000);
      send_all_modes(64'd0, 64'd100, 64'd100);
      send_all_modes(ALL_ONES, ALL_ONES, ALL_ONES);
      send_item(tntc_pkg::MODE_WAIT, 64'd1, 64'd5, ALL_ONES - 64'd20_000);
      send_item(tntc_pkg::MODE_WAIT, 64'd1, 64'd5, ALL_ONES - 64'd2_000);
      send_item(tntc_pkg::MODE_DEADLINE, 64'h0000_1000_0000_0000, 64'd7, 64'd0);
      end_burst();
      set_frequency(32'd1);
      send_all_modes(64'd1_000_000_000, 64'd1, 64'd0);
      end_burst();
      set_frequency(32'hFFFF_FFFF);
      send_all_modes(64'hFFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
      end_burst();
   endtask

   task automatic test_random(int count);
      logic [1:0]  mode;
      logic [63:0] amount;
      logic [63:0] now;
      logic [63:0] start;
      logic [31:0] hz;
      logic [71:0] wait_res;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) begin
            end_burst();
            case ($urandom_range(0, 5))
               0: hz = 32'd0;
               1: hz = 32'd1;
               2: hz = 32'hFFFF_FFFF;
               3: hz = 32'd1_000_000_000;
               default: hz = $urandom;
            endcase
            set_frequency(hz);
            no_gaps = ($urandom_range(0, 3) == 0);
         end
         mode = 2'($urandom_range(0, 3));
         now = {$urandom, $urandom};
         if ($urandom_range(0, 1)) amount = {$urandom, $urandom};
         else amount = 64'($urandom_range(0, 100_000));
         if ($urandom_range(0, 1)) begin
            start = {$urandom, $urandom};
         end else begin
            wait_res = convert(tntc_pkg::MODE_WAIT, amount, now, now);
            start = now - wait_res[63:0] + 64'($urandom_range(0, 4)) - 64'd2;
         end
         send_item(mode, amount, now, start);
      end
      end_burst();
   endtask

   initial begin
      logic [71:0] want;
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         results_checked++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer: got %h", rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[63:0] !== want[63:0] || rsp_tdata[64] !== want[64] ||
                rsp_tdata[65] !== want[65] || rsp_tdata[71:66] !== want[71:66]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: value exp %h got %h, done exp %b got %b, uncal exp %b got %b",
                     want[63:0], rsp_tdata[63:0], want[64], rsp_tdata[64],
                     want[65], rsp_tdata[65]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timebase_ns_tick_converter_tb NOT OK");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = 32'd0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      no_gaps = 1'b0;
      hz_model = 32'd0;
      ns_mult_model = 64'd0;
      ns_shift_model = 7'd0;
      tick_mult_model = 64'd0;
      tick_shift_model = 7'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_uncalibrated();
      test_directed();
      test_random(500);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d items over %0d frequency settings, checked %0d results.",
         items_sent, freq_writes, results_checked);
      $display("All four modes ran calibrated and uncalibrated; %0d mismatches.", mismatches);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("timebase_ns_tick_converter_tb OK");
      else
         $display("timebase_ns_tick_converter_tb NOT OK");
      $finish;
   end
endmodule
